>>> rtl/dacr_pkg.sv
// Shared constants and widths for the DAC ramp increment encoder.
package dacr_pkg;

	localparam int NUM_CHANNELS = 8;
	localparam int CH_AW        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	localparam int CHAN_W = 3;
	localparam int TIME_W = 30;
	localparam int TARG_W = 26;
	localparam int CUR_W  = 25;
	localparam int ACC_W  = 32;
	localparam int STEP_W = 16;
	localparam int CODE_W = 16;

	localparam int DIV_CNT_W = $clog2(ACC_W);

	localparam int IN_DATA_W  = 88;
	localparam int OUT_DATA_W = 56;

	localparam int CODE_OFFSET    = 'h8000;
	localparam int FULL_SCALE_UV  = 10000000;
	localparam int USECS_PER_STEP = 1000000 / 100;
	localparam int MAX_STEPS      = 65535;

	localparam logic signed [TARG_W-1:0] START_FROM_CUR = 26'sd20000000;

	// v * 32768 / 10^7 reduces to v * 256 / 78125.
	localparam logic [16:0] CODE_DIV   = 17'(FULL_SCALE_UV / 128);
	localparam logic [23:0] RECIP_CODE = 24'((64'd1 << 40) / 64'(FULL_SCALE_UV / 128));
	localparam logic [26:0] RECIP_STEP = 27'((64'd1 << 40) / 64'(USECS_PER_STEP));

endpackage

>>> rtl/dacr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module dacr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/dacr_div.sv
// Radix-2 restoring divider: accumulator distance over the step count.
module dacr_div import dacr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [ACC_W-1:0]  dividend,
	input  logic [STEP_W-1:0] divisor,
	output logic              done,
	output logic [ACC_W-1:0]  quotient,
	output logic [STEP_W-1:0] remainder
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [ACC_W-1:0]     quo_q;
	logic [STEP_W-1:0]    rem_q;
	logic [STEP_W-1:0]    divisor_q;

	logic [STEP_W:0] trial;
	logic [STEP_W:0] diff;
	logic            ge;

	// The dividend shifts out at the top while quotient bits enter at the bottom.
	assign trial = {rem_q, quo_q[ACC_W-1]};
	assign diff  = trial - {1'b0, divisor_q};
	assign ge    = trial >= {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(ACC_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q     <= dividend;
			rem_q     <= '0;
			divisor_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[ACC_W-2:0], ge};
			rem_q <= ge ? diff[STEP_W-1:0] : trial[STEP_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

>>> rtl/dac_ramp_table_increment_encoder_unit.sv
// Top level of the DAC ramp increment encoder: sequencer, converters and accumulator RAM.
// One item at a time. A first-row item passes the multiply, code and prepare states and
// writes the channel's accumulator without an output; a later row of an unaffected
// channel then goes to the output state, and one of an affected channel first waits out
// the bit-serial divide of the 32-bit distance. The output state waits while the output
// holds an earlier result that has not been taken.
// Reset clears the sequencer and the output valid; accumulators hold nothing until written.
module dac_ramp_table_increment_encoder_unit import dacr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// channel, affected, row_time_us, target_value, current_value, zero fill
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// first_row
	input  logic                  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// out_channel, step_count, increment, zero fill
	output logic [OUT_DATA_W-1:0] m_tdata
);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_MUL1 = 7'b0000010,
		S_MUL2 = 7'b0000100,
		S_CODE = 7'b0001000,
		S_PREP = 7'b0010000,
		S_DIV  = 7'b0100000,
		S_OUT  = 7'b1000000
	} state_t;

	state_t state_q;

	// Input fields.
	logic [CHAN_W-1:0] in_chan;
	logic              in_aff;
	logic [TIME_W-1:0] in_time;
	logic [TARG_W-1:0] in_targ;
	logic [CUR_W-1:0]  in_cur;
	logic [TARG_W-1:0] in_src;
	logic              in_accept;

	assign in_chan   = s_tdata[2:0];
	assign in_aff    = s_tdata[3];
	assign in_time   = s_tdata[33:4];
	assign in_targ   = s_tdata[59:34];
	assign in_cur    = s_tdata[84:60];
	assign in_accept = s_tvalid && s_tready;
	assign s_tready  = (state_q == S_IDLE);

	// A first row whose target carries the marker converts the present output instead.
	assign in_src = (s_tuser && ($signed(in_targ) >= START_FROM_CUR)) ?
		{in_cur[CUR_W-1], in_cur} : in_targ;

	// Item registers.
	logic              first_q;
	logic [CHAN_W-1:0] chan_q;
	logic              aff_q;
	logic [TIME_W-1:0] time_q;
	logic [TARG_W-1:0] mag_q;
	logic              neg_q;
	logic [ACC_W-1:0]  acc_q;
	logic [49:0]       p_code_q;
	logic [56:0]       p_time_q;
	logic [34:0]       m_code_q;
	logic [30:0]       m_time_q;
	logic [CODE_W-1:0] code_q;
	logic [STEP_W-1:0] steps_q;
	logic              up_q;
	logic              wr_pend_q;
	logic [ACC_W-1:0]  nacc_q;
	logic [ACC_W-1:0]  incr_q;
	logic              out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	logic ch_ok;
	assign ch_ok = (32'(chan_q) < NUM_CHANNELS);

	// Reciprocal quotient estimates, one short at most, and their corrections.
	logic [17:0] q0_code;
	logic [16:0] q0_time;
	logic [34:0] r_code;
	logic [30:0] r_time;
	logic [18:0] qc;
	logic [17:0] qt;
	logic signed [19:0] csum;
	logic [CODE_W-1:0]  code_sat;
	logic [STEP_W-1:0]  steps_sat;

	assign q0_code = p_code_q[49:32];
	assign q0_time = p_time_q[56:40];
	assign r_code  = {1'b0, mag_q, 8'd0} - m_code_q;
	assign r_time  = {1'b0, time_q} - m_time_q;
	assign qc      = {1'b0, q0_code} + 19'(r_code >= 35'(CODE_DIV));
	assign qt      = {1'b0, q0_time} + 18'(r_time >= 31'(USECS_PER_STEP));
	assign csum    = neg_q ? (20'sd32768 - $signed({1'b0, qc})) :
		(20'sd32768 + $signed({1'b0, qc}));

	always_comb begin
		if (csum < 20'sd0) begin
			code_sat = '0;
		end else if (csum > 20'sd65535) begin
			code_sat = '1;
		end else begin
			code_sat = csum[CODE_W-1:0];
		end
		if (qt == '0) begin
			steps_sat = STEP_W'(1);
		end else if (qt > 18'(MAX_STEPS)) begin
			steps_sat = STEP_W'(MAX_STEPS);
		end else begin
			steps_sat = qt[STEP_W-1:0];
		end
	end

	// Accumulator RAM and divider.
	logic [ACC_W-1:0]  targ;
	logic [ACC_W-1:0]  ram_rdata;
	logic              ram_we;
	logic [ACC_W-1:0]  ram_wdata;
	logic              div_start;
	logic [ACC_W-1:0]  div_dividend;
	logic              div_done;
	logic [ACC_W-1:0]  div_quo;
	logic [STEP_W-1:0] div_rem;
	logic              out_load;
	logic              acc_up;

	assign targ     = {code_q, 16'd0};
	assign acc_up   = acc_q < targ;
	assign out_load = (state_q == S_OUT) && (!out_valid_q || m_tready);

	always_comb begin
		ram_we       = 1'b0;
		ram_wdata    = nacc_q;
		div_start    = 1'b0;
		div_dividend = acc_up ? (targ - acc_q) : (acc_q - targ);
		case (state_q)
			S_PREP: begin
				if (first_q) begin
					ram_we    = ch_ok;
					ram_wdata = aff_q ? targ : '0;
				end else if (ch_ok && aff_q) begin
					div_start = 1'b1;
				end
			end
			S_OUT: begin
				ram_we = out_load && wr_pend_q;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	dacr_ram #(
		.WIDTH(ACC_W),
		.DEPTH(NUM_CHANNELS)
	) u_acc_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(CH_AW'(chan_q)),
		.wdata(ram_wdata),
		.raddr(CH_AW'(in_chan)),
		.rdata(ram_rdata)
	);

	dacr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (steps_q),
		.done     (div_done),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	// Sequencer and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						state_q <= S_MUL1;
					end
				end
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: state_q <= S_CODE;
				S_CODE: state_q <= S_PREP;
				S_PREP: begin
					if (first_q) begin
						state_q <= S_IDLE;
					end else if (ch_ok && aff_q) begin
						state_q <= S_DIV;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			first_q <= s_tuser;
			chan_q  <= in_chan;
			aff_q   <= in_aff;
			time_q  <= in_time;
			neg_q   <= in_src[TARG_W-1];
			mag_q   <= in_src[TARG_W-1] ? (TARG_W'(0) - in_src) : in_src;
		end
		if (state_q == S_MUL1) begin
			acc_q    <= ram_rdata;
			p_code_q <= {24'd0, mag_q} * {26'd0, RECIP_CODE};
			p_time_q <= {27'd0, time_q} * {30'd0, RECIP_STEP};
		end
		if (state_q == S_MUL2) begin
			m_code_q <= {17'd0, q0_code} * {18'd0, CODE_DIV};
			m_time_q <= {14'd0, q0_time} * 31'(USECS_PER_STEP);
		end
		if (state_q == S_CODE) begin
			code_q  <= code_sat;
			steps_q <= steps_sat;
		end
		if (state_q == S_PREP) begin
			up_q      <= acc_up;
			incr_q    <= '0;
			wr_pend_q <= 1'b0;
		end
		// Since distance = quotient * steps + remainder, the advanced accumulator lands the
		// remainder short of the target: below it on the way up and above it on the way down.
		if ((state_q == S_DIV) && div_done) begin
			incr_q    <= up_q ? div_quo : (ACC_W'(0) - div_quo);
			nacc_q    <= up_q ? (targ - {16'd0, div_rem}) : (targ + {16'd0, div_rem});
			wr_pend_q <= 1'b1;
		end
		if (out_load) begin
			out_data_q <= {5'd0, incr_q, steps_q, chan_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule
